### hw/rtl/dsha_pkg.sv
// ----------------------------------------------------------------------------
// dsha_pkg
// Types, constants and round functions shared by the double SHA-256 pipeline.
// ----------------------------------------------------------------------------
package dsha_pkg;

   typedef logic [31:0] word_type;

   typedef struct packed {
      word_type a;
      word_type b;
      word_type c;
      word_type d;
      word_type e;
      word_type f;
      word_type g;
      word_type h;
   } chain_type;

   typedef word_type [15:0] window_type;

   localparam int Rounds = 64;
   localparam word_type PadMarker = 32'h8000_0000;
   localparam word_type HeaderBits = 32'd640;
   localparam word_type DigestBits = 32'd256;

   localparam word_type [0:63] RoundK = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam chain_type InitialH = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   function automatic word_type rotr(input word_type x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   // One compression round on the chain value with the current schedule word.
   function automatic chain_type round_step(input chain_type v, input word_type k,
                                            input word_type w);
      word_type big1, choose, t1, big0, major, t2;
      chain_type r;
      big1 = rotr(v.e, 6) ^ rotr(v.e, 11) ^ rotr(v.e, 25);
      choose = (v.e & v.f) ^ (~v.e & v.g);
      t1 = v.h + big1 + choose + k + w;
      big0 = rotr(v.a, 2) ^ rotr(v.a, 13) ^ rotr(v.a, 22);
      major = (v.a & v.b) ^ (v.a & v.c) ^ (v.b & v.c);
      t2 = big0 + major;
      r.h = v.g; r.g = v.f; r.f = v.e; r.e = v.d + t1;
      r.d = v.c; r.c = v.b; r.b = v.a; r.a = t1 + t2;
      round_step = r;
   endfunction

   // Slide the 16-word message window by one, appending the next schedule word.
   function automatic window_type window_step(input window_type m);
      word_type s0, s1;
      window_type r;
      s0 = rotr(m[1], 7) ^ rotr(m[1], 18) ^ (m[1] >> 3);
      s1 = rotr(m[14], 17) ^ rotr(m[14], 19) ^ (m[14] >> 10);
      for (int i = 0; i < 15; i++) begin
         r[i] = m[i + 1];
      end
      r[15] = m[0] + s0 + m[9] + s1;
      window_step = r;
   endfunction

   function automatic chain_type chain_add(input chain_type x, input chain_type y);
      chain_type r;
      r.a = x.a + y.a; r.b = x.b + y.b; r.c = x.c + y.c; r.d = x.d + y.d;
      r.e = x.e + y.e; r.f = x.f + y.f; r.g = x.g + y.g; r.h = x.h + y.h;
      chain_add = r;
   endfunction

endpackage

### hw/rtl/double_sha256_header_from_midstate_unit.sv
// ----------------------------------------------------------------------------
// double_sha256_header_from_midstate_unit
// Double SHA-256 of an 80-byte header finished from a configured midstate.
// ----------------------------------------------------------------------------
// One item enters per cycle while the pipeline advances. An input transfer
// passes through 64 round stages for each of the two compressions plus one output
// register. The whole pipeline advances together and freezes while the output
// register holds a result that is not taken, so throughput is one per cycle
// whenever the consumer keeps rsp_ready high.
module double_sha256_header_from_midstate_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_tail_word_0,
   input  logic [31:0] req_tail_word_1,
   input  logic [31:0] req_tail_word_2,
   input  logic [31:0] req_tail_word_3,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_digest_words_0_1,
   output logic [63:0] rsp_digest_words_2_3,
   output logic [63:0] rsp_digest_words_4_5,
   output logic [63:0] rsp_digest_words_6_7
);
   import dsha_pkg::*;

   localparam logic [1:0] RegMid01 = 2'd0;
   localparam logic [1:0] RegMid23 = 2'd1;
   localparam logic [1:0] RegMid45 = 2'd2;
   localparam logic [1:0] RegMid67 = 2'd3;

   logic [63:0] mid01_ff, mid23_ff, mid45_ff, mid67_ff;
   logic        advance;
   logic        first_valid, second_valid;
   chain_type   first_chain, second_chain, midstate;
   window_type  first_block, second_block;
   logic        rsp_valid_ff;
   chain_type   digest_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mid01_ff <= '0; mid23_ff <= '0; mid45_ff <= '0; mid67_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            RegMid01: mid01_ff <= csr_data;
            RegMid23: mid23_ff <= csr_data;
            RegMid45: mid45_ff <= csr_data;
            RegMid67: mid67_ff <= csr_data;
            default:  mid01_ff <= mid01_ff;
         endcase
      end
   end

   // The pipeline moves whenever the output slot is free or is being drained.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   assign midstate = '{mid01_ff[63:32], mid01_ff[31:0], mid23_ff[63:32], mid23_ff[31:0],
                       mid45_ff[63:32], mid45_ff[31:0], mid67_ff[63:32], mid67_ff[31:0]};

   always_comb begin
      first_block     = '0;
      first_block[0]  = req_tail_word_0;
      first_block[1]  = req_tail_word_1;
      first_block[2]  = req_tail_word_2;
      first_block[3]  = req_tail_word_3;
      first_block[4]  = PadMarker;
      first_block[15] = HeaderBits;
   end

   dsha_compress u_first (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_chain  (midstate),
      .in_block  (first_block),
      .out_valid (first_valid),
      .out_chain (first_chain)
   );

   always_comb begin
      second_block     = '0;
      second_block[0]  = first_chain.a;
      second_block[1]  = first_chain.b;
      second_block[2]  = first_chain.c;
      second_block[3]  = first_chain.d;
      second_block[4]  = first_chain.e;
      second_block[5]  = first_chain.f;
      second_block[6]  = first_chain.g;
      second_block[7]  = first_chain.h;
      second_block[8]  = PadMarker;
      second_block[15] = DigestBits;
   end

   dsha_compress u_second (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (first_valid),
      .in_chain  (InitialH),
      .in_block  (second_block),
      .out_valid (second_valid),
      .out_chain (second_chain)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= second_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         digest_ff <= second_chain;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_digest_words_0_1 = {digest_ff.a, digest_ff.b};
   assign rsp_digest_words_2_3 = {digest_ff.c, digest_ff.d};
   assign rsp_digest_words_4_5 = {digest_ff.e, digest_ff.f};
   assign rsp_digest_words_6_7 = {digest_ff.g, digest_ff.h};

   // A stalled result must hold until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_digest_words_0_1))
      else $error("result changed while stalled");

   // Input is taken exactly when the output slot can move.
   assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("input ready does not follow output slot");

   // Every result leaving the second compression lands in the output register.
   assert property (@(posedge clock) disable iff (reset)
      advance && second_valid |=> rsp_valid)
      else $error("result lost at output register");

endmodule

### hw/rtl/dsha_compress.sv
// ----------------------------------------------------------------------------
// dsha_compress
// Fully unrolled SHA-256 compression, one round per register stage.
// ----------------------------------------------------------------------------
module dsha_compress (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  dsha_pkg::chain_type   in_chain,
   input  dsha_pkg::window_type  in_block,
   output logic                  out_valid,
   output dsha_pkg::chain_type   out_chain
);
   import dsha_pkg::*;

   localparam int Stages = Rounds;

   logic       [Stages:1] valid_ff;
   chain_type  [Stages:1] work_ff;
   chain_type  [Stages:1] base_ff;
   window_type [Stages:1] sched_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[Stages-1:1], in_valid};
      end
   end

   // Stage t+1 holds the result of round t, which uses schedule word t at the
   // head of the window.
   always_ff @(posedge clock) begin
      if (advance) begin
         work_ff[1]  <= round_step(in_chain, RoundK[0], in_block[0]);
         base_ff[1]  <= in_chain;
         sched_ff[1] <= window_step(in_block);
         for (int t = 1; t < Stages; t++) begin
            work_ff[t + 1]  <= round_step(work_ff[t], RoundK[t], sched_ff[t][0]);
            base_ff[t + 1]  <= base_ff[t];
            sched_ff[t + 1] <= window_step(sched_ff[t]);
         end
      end
   end

   assign out_valid = valid_ff[Stages];
   assign out_chain = chain_add(work_ff[Stages], base_ff[Stages]);

endmodule

### tb/tb_double_sha256_header_from_midstate_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_double_sha256_header_from_midstate_unit
// Self-checking bench for the midstate double SHA-256 header pipeline.
// Header tails are pushed through a valid/ready driver. Each transfer is hashed
// by a local predictor against the current midstate, and the monitor compares
// every digest in order. The run steps through several midstate settings and
// several idling profiles, including one long consumer hold-off.
// ----------------------------------------------------------------------------
module tb_double_sha256_header_from_midstate_unit;
   import dsha_pkg::*;

   localparam int PipeLatency = 129;
   localparam int StallLimit = 5000;

   typedef struct packed {
      word_type w0, w1, w2, w3;
   } tail_type;

   typedef struct packed {
      logic [63:0] d01, d23, d45, d67;
   } digest_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic [1:0] csr_index = '0;
   logic [63:0] csr_data = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [31:0] req_tail_word_0 = '0, req_tail_word_1 = '0;
   logic [31:0] req_tail_word_2 = '0, req_tail_word_3 = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [63:0] rsp_digest_words_0_1, rsp_digest_words_2_3;
   logic [63:0] rsp_digest_words_4_5, rsp_digest_words_6_7;

   double_sha256_header_from_midstate_unit uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   tail_type pending_tails[$];
   digest_type expected_digests[$];
   logic [63:0] midstate_regs[4];
   logic req_accepted = 1'b0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_off_cycles = 0;
   int error_count = 0;
   int digests_checked = 0;
   int stall_cycles = 0;

   function automatic word_type rot_right(word_type x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic void sha_compress(ref word_type hv[8], input word_type blk[16]);
      word_type sched[64];
      word_type v[8];
      word_type t1, t2;
      for (int t = 0; t < 16; t++) sched[t] = blk[t];
      for (int t = 16; t < 64; t++)
         sched[t] = sched[t-16] + sched[t-7]
            + (rot_right(sched[t-15], 7) ^ rot_right(sched[t-15], 18) ^ (sched[t-15] >> 3))
            + (rot_right(sched[t-2], 17) ^ rot_right(sched[t-2], 19) ^ (sched[t-2] >> 10));
      for (int t = 0; t < 8; t++) v[t] = hv[t];
      for (int t = 0; t < 64; t++) begin
         t1 = v[7] + (rot_right(v[4], 6) ^ rot_right(v[4], 11) ^ rot_right(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[t] + sched[t];
         t2 = (rot_right(v[0], 2) ^ rot_right(v[0], 13) ^ rot_right(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int t = 0; t < 8; t++) hv[t] += v[t];
   endfunction

   function automatic digest_type header_digest(tail_type tl);
      word_type hv[8];
      word_type blk[16];
      digest_type d;
      for (int i = 0; i < 4; i++) begin
         hv[2*i] = midstate_regs[i][63:32];
         hv[2*i+1] = midstate_regs[i][31:0];
      end
      foreach (blk[i]) blk[i] = '0;
      blk[0] = tl.w0; blk[1] = tl.w1; blk[2] = tl.w2; blk[3] = tl.w3;
      blk[4] = PadMarker;
      blk[15] = HeaderBits;
      sha_compress(hv, blk);
      foreach (blk[i]) blk[i] = '0;
      for (int i = 0; i < 8; i++) blk[i] = hv[i];
      blk[8] = PadMarker;
      blk[15] = DigestBits;
      hv = '{InitialH.a, InitialH.b, InitialH.c, InitialH.d,
             InitialH.e, InitialH.f, InitialH.g, InitialH.h};
      sha_compress(hv, blk);
      d.d01 = {hv[0], hv[1]}; d.d23 = {hv[2], hv[3]};
      d.d45 = {hv[4], hv[5]}; d.d67 = {hv[6], hv[7]};
      return d;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Driver: the payload is held until the transfer completes.
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_accepted) begin
            if (pending_tails.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               tail_type tl;
               tl = pending_tails.pop_front();
               req_tail_word_0 <= tl.w0; req_tail_word_1 <= tl.w1;
               req_tail_word_2 <= tl.w2; req_tail_word_3 <= tl.w3;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: a hold-off forces ready low for a counted number of cycles.
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Request transfers are logged at the same edge they complete, so the
   // expectation always exists long before its response arrives.
   always @(posedge clock) begin
      if (!reset) begin
         req_accepted = req_valid && req_ready;
         if (req_accepted) begin
            expected_digests.push_back(header_digest(
               {req_tail_word_0, req_tail_word_1, req_tail_word_2, req_tail_word_3}));
         end
         if (req_accepted || (rsp_valid && rsp_ready)) stall_cycles <= 0;
         else stall_cycles <= stall_cycles + 1;
         if (rsp_valid && rsp_ready) begin
            if (expected_digests.size() == 0) begin
               $display("unexpected digest transfer at %0t", $realtime);
               error_count++;
            end else begin
               digest_type want;
               want = expected_digests.pop_front();
               if (rsp_digest_words_0_1 !== want.d01)
                  report_mismatch("digest_words_0_1", rsp_digest_words_0_1, want.d01);
               if (rsp_digest_words_2_3 !== want.d23)
                  report_mismatch("digest_words_2_3", rsp_digest_words_2_3, want.d23);
               if (rsp_digest_words_4_5 !== want.d45)
                  report_mismatch("digest_words_4_5", rsp_digest_words_4_5, want.d45);
               if (rsp_digest_words_6_7 !== want.d67)
                  report_mismatch("digest_words_6_7", rsp_digest_words_6_7, want.d67);
               digests_checked++;
            end
         end
         if (stall_cycles > StallLimit) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   task automatic write_midstate(int idx, logic [63:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx[1:0];
      csr_data <= value;
      midstate_regs[idx] = value;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic drain();
      while (pending_tails.size() > 0 || req_valid || expected_digests.size() > 0)
         @(negedge clock);
      repeat (PipeLatency + 10) @(negedge clock);
   endtask

   function automatic tail_type random_tail();
      return {$urandom, $urandom, $urandom, $urandom};
   endfunction

   initial begin
      tail_type tl;
      foreach (midstate_regs[i]) midstate_regs[i] = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Unwritten midstate stays all zero for the first directed items.
      pending_tails.push_back('0);
      pending_tails.push_back('1);
      pending_tails.push_back({32'h0, 32'h0, 32'h0, 32'h1});
      pending_tails.push_back({32'h8000_0000, 32'h0, 32'h0, 32'hffff_ffff});
      pending_tails.push_back({32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa});
      drain();
      for (int i = 0; i < 4; i++) write_midstate(i, '1);
      pending_tails.push_back('0);
      pending_tails.push_back('1);
      pending_tails.push_back(random_tail());
      drain();
      for (int i = 0; i < 4; i++) write_midstate(i, {$urandom, $urandom});
      for (int i = 0; i < 12; i++) pending_tails.push_back(random_tail());
      drain();

      // Random phases, each with a fresh midstate and idling profile.
      for (int phase = 0; phase < 4; phase++) begin
         for (int i = 0; i < 4; i++) begin
            if (phase == 3) write_midstate(i, 64'h8000_0000_0000_0001 << i);
            else write_midstate(i, {$urandom, $urandom});
         end
         send_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 85 : 0;
         recv_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 27 : 0;
         if (phase == 2) hold_off_cycles = 400;
         for (int i = 0; i < 210; i++) begin
            tl = random_tail();
            if ($urandom_range(9) == 0) tl.w3 = 32'(i);
            pending_tails.push_back(tl);
         end
         drain();
      end

      $display("checked %0d digests over several midstate settings and idling profiles",
               digests_checked);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
